// ===== sv/vigenere_caesar_letter_shift_assert.svh =====
// ----------------------------------------------------------------------------
// vigenere_caesar_letter_shift_assert.svh
// Assertion macros shared by the letter shifter modules.
// ----------------------------------------------------------------------------
`ifndef VIGENERE_CAESAR_LETTER_SHIFT_ASSERT_SVH
`define VIGENERE_CAESAR_LETTER_SHIFT_ASSERT_SVH

// Condition must never hold outside reset.
`define VCLS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define VCLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vcls_pkg.sv =====
// ----------------------------------------------------------------------------
// vcls_pkg
// Types, alphabet tables and helper functions of the letter shifter.
// ----------------------------------------------------------------------------
`default_nettype none

package vcls_pkg;

    localparam int KEY_SLOTS_DEF = 12;
    localparam int KEY_SLOTS_MAX = 12;
    localparam int UKR_LEN       = 33;
    localparam int ENG_LEN       = 26;
    localparam int QDEPTH        = 2;

    // Residue of 2^16 for the signed shift correction
    localparam int UKR_WRAP = 65536 % UKR_LEN;
    localparam int ENG_WRAP = 65536 % ENG_LEN;

    // Floor reciprocals, scaled by 2^21
    localparam int RECIP_SH  = 21;
    localparam int UKR_RECIP = (1 << RECIP_SH) / UKR_LEN;
    localparam int ENG_RECIP = (1 << RECIP_SH) / ENG_LEN;

    localparam logic [15:0] ENG_UP_BASE = 16'h0041;
    localparam logic [15:0] ENG_UP_LAST = 16'h005A;
    localparam logic [15:0] ENG_LO_BASE = 16'h0061;
    localparam logic [15:0] ENG_LO_LAST = 16'h007A;

    localparam logic [15:0] UA_CAPITAL [0:UKR_LEN-1] = '{
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0490, 16'h0414, 16'h0415,
        16'h0404, 16'h0416, 16'h0417, 16'h0418, 16'h0406, 16'h0407, 16'h0419,
        16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F, 16'h0420,
        16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042C, 16'h042E, 16'h042F
    };
    localparam logic [15:0] UA_SMALL [0:UKR_LEN-1] = '{
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0491, 16'h0434, 16'h0435,
        16'h0454, 16'h0436, 16'h0437, 16'h0438, 16'h0456, 16'h0457, 16'h0439,
        16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F, 16'h0440,
        16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044C, 16'h044E, 16'h044F
    };

    // Configuration register indexes (byte address / 8)
    typedef enum logic [2:0] {
        REG_CAESAR_MODE  = 3'd0,
        REG_DECRYPT_MODE = 3'd1,
        REG_CAESAR_SHIFT = 3'd2,
        REG_KEY_LENGTH   = 3'd3,
        REG_KEY_LOW      = 3'd4,
        REG_KEY_MID      = 3'd5,
        REG_KEY_HIGH     = 3'd6,
        REG_UNUSED       = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_UKR_UP = 3'd1,
        CLS_UKR_LO = 3'd2,
        CLS_ENG_UP = 3'd3,
        CLS_ENG_LO = 3'd4
    } t_cls;

    typedef struct packed {
        logic [15:0] char_in;
        logic        message_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0] char_out;
        logic        was_letter;
    } t_out_item;

    typedef struct packed {
        t_cls       cls;
        logic [5:0] pos;
    } t_letter;

    // Work queued between front and back
    typedef struct packed {
        logic [15:0] char_in;
        t_cls        cls;
        logic [5:0]  pos;
        logic [5:0]  shift;
    } t_work;

    // Settings seen by front and back
    typedef struct packed {
        logic       caesar_mode;
        logic       decrypt_mode;
        logic [3:0] key_length;
        logic [5:0] shift_ukr;
        logic [5:0] shift_eng;
    } t_cfg;

    // Find the alphabet and position of a code unit
    function automatic t_letter f_classify(input logic [15:0] c);
        t_letter r;
        r.cls = CLS_NONE;
        r.pos = '0;
        for (int i = 0; i < UKR_LEN; i++) begin
            if (c == UA_CAPITAL[i]) begin
                r.cls = CLS_UKR_UP;
                r.pos = 6'(i);
            end
            if (c == UA_SMALL[i]) begin
                r.cls = CLS_UKR_LO;
                r.pos = 6'(i);
            end
        end
        if (c >= ENG_UP_BASE && c <= ENG_UP_LAST) begin
            r.cls = CLS_ENG_UP;
            r.pos = 6'(c - ENG_UP_BASE);
        end
        if (c >= ENG_LO_BASE && c <= ENG_LO_LAST) begin
            r.cls = CLS_ENG_LO;
            r.pos = 6'(c - ENG_LO_BASE);
        end
        return r;
    endfunction

    // Unsigned residue by a small constant: reciprocal multiply, one correction
    function automatic logic [5:0] f_mod_const(input logic [15:0] x,
                                               input logic [16:0] len,
                                               input logic [16:0] recip);
        logic [32:0] prod;
        logic [11:0] q;
        logic [16:0] r;
        prod = 33'(x) * 33'(recip);
        q    = prod[32:RECIP_SH];
        r    = 17'(x) - 17'(q) * len;
        if (r >= len) begin
            r = r - len;
        end
        return 6'(r);
    endfunction

    // Non-negative residue of a signed 16-bit shift
    function automatic logic [5:0] f_signed_mod(input logic [15:0] x,
                                                input logic [16:0] len,
                                                input logic [16:0] recip,
                                                input logic [5:0] wrap);
        logic [5:0] r;
        logic [5:0] len6;
        r    = f_mod_const(x, len, recip);
        len6 = 6'(len);
        if (x[15]) begin
            r = (r >= wrap) ? (r - wrap) : (r + (len6 - wrap));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/vcls_regs.sv =====
// ----------------------------------------------------------------------------
// vcls_regs
// Configuration registers with APB-style access; keeps per-slot key shifts
// and shift residues worked out at write time.
// ----------------------------------------------------------------------------
`default_nettype none

module vcls_regs
    import vcls_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [5:0]                  paddr,
    input  wire logic [63:0]                 pwdata,
    output logic      [63:0]                 prdata,
    output logic                             pready,
    output t_cfg                             o_cfg,
    output logic      [KEY_SLOTS-1:0][5:0]   o_key_shift
);

    logic        r_caesar_mode;
    logic        r_decrypt_mode;
    logic [15:0] r_caesar_shift;
    logic [3:0]  r_key_length;
    logic [63:0] r_key_low;
    logic [63:0] r_key_mid;
    logic [63:0] r_key_high;
    logic [5:0]  r_shift_ukr;
    logic [5:0]  r_shift_eng;
    logic [5:0]  n_shift_ukr;
    logic [5:0]  n_shift_eng;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[5:3]);

    // Reduce the written Caesar shift for each alphabet
    assign n_shift_ukr = f_signed_mod(pwdata[15:0], 17'(UKR_LEN), 17'(UKR_RECIP),
                                      6'(UKR_WRAP));
    assign n_shift_eng = f_signed_mod(pwdata[15:0], 17'(ENG_LEN), 17'(ENG_RECIP),
                                      6'(ENG_WRAP));

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caesar_mode  <= 1'b0;
            r_decrypt_mode <= 1'b0;
            r_caesar_shift <= '0;
            r_key_length   <= '0;
            r_key_low      <= '0;
            r_key_mid      <= '0;
            r_key_high     <= '0;
            r_shift_ukr    <= '0;
            r_shift_eng    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CAESAR_MODE:  r_caesar_mode  <= pwdata[0];
                REG_DECRYPT_MODE: r_decrypt_mode <= pwdata[0];
                REG_CAESAR_SHIFT: begin
                    r_caesar_shift <= pwdata[15:0];
                    r_shift_ukr    <= n_shift_ukr;
                    r_shift_eng    <= n_shift_eng;
                end
                REG_KEY_LENGTH:   r_key_length   <= pwdata[3:0];
                REG_KEY_LOW:      r_key_low      <= pwdata;
                REG_KEY_MID:      r_key_mid      <= pwdata;
                REG_KEY_HIGH:     r_key_high     <= pwdata;
                default: ;
            endcase
        end
    end

    // Classify each key character as it is written; keep its position
    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
        localparam int       WORD = g / 4;
        localparam int       LANE = g % 4;
        localparam t_reg_idx SLOT_REG = t_reg_idx'(3'(int'(REG_KEY_LOW) + WORD));
        logic [5:0] r_pos;
        t_letter    kl;

        assign kl = f_classify(pwdata[16*LANE +: 16]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pos <= '0;
            end else if (wr_en && reg_idx == SLOT_REG) begin
                r_pos <= kl.pos;
            end
        end

        assign o_key_shift[g] = r_pos;
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_CAESAR_MODE:  prdata = {63'b0, r_caesar_mode};
            REG_DECRYPT_MODE: prdata = {63'b0, r_decrypt_mode};
            REG_CAESAR_SHIFT: prdata = {48'b0, r_caesar_shift};
            REG_KEY_LENGTH:   prdata = {60'b0, r_key_length};
            REG_KEY_LOW:      prdata = r_key_low;
            REG_KEY_MID:      prdata = r_key_mid;
            REG_KEY_HIGH:     prdata = r_key_high;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.caesar_mode  = r_caesar_mode;
    assign o_cfg.decrypt_mode = r_decrypt_mode;
    assign o_cfg.key_length   = r_key_length;
    assign o_cfg.shift_ukr    = r_shift_ukr;
    assign o_cfg.shift_eng    = r_shift_eng;

endmodule

`default_nettype wire

// ===== sv/vcls_front.sv =====
// ----------------------------------------------------------------------------
// vcls_front
// Accepts characters, classifies them, tracks the key position and picks
// the shift amount for each letter.
// ----------------------------------------------------------------------------
`default_nettype none

module vcls_front
    import vcls_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  t_in_item                       i_in,
    input  t_cfg                           i_cfg,
    input  wire logic [KEY_SLOTS-1:0][5:0] i_key_shift,
    input  wire logic                      i_q_full,
    output logic                           o_q_push,
    output t_work                          o_q_data
);

    localparam int KPW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [3:0] SLOTS4 = 4'(KEY_SLOTS);

    logic [KPW-1:0] r_key_pos;
    logic [KPW-1:0] n_key_pos;
    logic [KPW-1:0] kp_cur;
    logic [KPW-1:0] idx;
    logic [3:0]     klen;
    logic [3:0]     idx_inc;
    logic [5:0]     kshift;
    logic [5:0]     vshift;
    logic           is_ukr;
    logic           is_letter;
    t_letter        lt;

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    // Effective key length and current slot
    assign klen    = (i_cfg.key_length > SLOTS4) ? SLOTS4 : i_cfg.key_length;
    assign kp_cur  = i_in.message_start ? '0 : r_key_pos;
    assign idx     = (4'(kp_cur) >= klen) ? '0 : kp_cur;
    assign idx_inc = 4'(idx) + 4'd1;

    assign lt        = f_classify(i_in.char_in);
    assign is_letter = (lt.cls != CLS_NONE);
    assign is_ukr    = (lt.cls == CLS_UKR_UP) || (lt.cls == CLS_UKR_LO);

    // Key shift, reduced for the shorter alphabet
    assign kshift = i_key_shift[idx];
    always_comb begin
        if (klen == 4'd0) begin
            vshift = '0;
        end else if (!is_ukr && kshift >= 6'(ENG_LEN)) begin
            vshift = kshift - 6'(ENG_LEN);
        end else begin
            vshift = kshift;
        end
    end

    // Build the queue entry
    always_comb begin
        o_q_data.char_in = i_in.char_in;
        o_q_data.cls     = lt.cls;
        o_q_data.pos     = lt.pos;
        if (i_cfg.caesar_mode) begin
            o_q_data.shift = is_ukr ? i_cfg.shift_ukr : i_cfg.shift_eng;
        end else begin
            o_q_data.shift = vshift;
        end
    end

    // Advance the key position on letters only
    always_comb begin
        if (!is_letter) begin
            n_key_pos = kp_cur;
        end else if (klen == 4'd0 || idx_inc >= klen) begin
            n_key_pos = '0;
        end else begin
            n_key_pos = KPW'(idx_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos <= '0;
        end else if (o_q_push) begin
            r_key_pos <= n_key_pos;
        end
    end

`include "vigenere_caesar_letter_shift_assert.svh"

    `VCLS_ASSERT_NEVER(a_key_pos_range, i_clk, i_rst_n, int'(r_key_pos) >= KEY_SLOTS, "key position beyond slots")

endmodule

`default_nettype wire

// ===== sv/vcls_fifo.sv =====
// ----------------------------------------------------------------------------
// vcls_fifo
// Short queue of classified work between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module vcls_fifo
    import vcls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_work     i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_work     o_data
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_work           r_mem [QDEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`include "vigenere_caesar_letter_shift_assert.svh"

    `VCLS_ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `VCLS_ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `VCLS_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

// ===== sv/vcls_back.sv =====
// ----------------------------------------------------------------------------
// vcls_back
// Applies the shift within the letter's alphabet, maps the new position
// back to a code unit and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcls_back
    import vcls_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_q_empty,
    input  t_work     i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_item o_out
);

    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       load;
    logic       is_ukr;
    logic [5:0] len;
    logic [6:0] sum;
    logic [6:0] wrapped;
    logic [5:0] np;
    t_letter    out_lt;

    // Take new work whenever the output register is free or draining
    assign load    = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_q_pop = load;

    assign is_ukr = (i_q_data.cls == CLS_UKR_UP) || (i_q_data.cls == CLS_UKR_LO);
    assign len    = is_ukr ? 6'(UKR_LEN) : 6'(ENG_LEN);

    // Modular shift: both operands are below the alphabet length
    always_comb begin
        if (i_cfg.decrypt_mode) begin
            sum = 7'(i_q_data.pos) + 7'(len) - 7'(i_q_data.shift);
        end else begin
            sum = 7'(i_q_data.pos) + 7'(i_q_data.shift);
        end
        wrapped = (sum >= 7'(len)) ? (sum - 7'(len)) : sum;
        np      = 6'(wrapped);
    end

    // Map the new position to a code unit
    always_comb begin
        n_out.was_letter = 1'b1;
        case (i_q_data.cls)
            CLS_UKR_UP: n_out.char_out = UA_CAPITAL[np];
            CLS_UKR_LO: n_out.char_out = UA_SMALL[np];
            CLS_ENG_UP: n_out.char_out = ENG_UP_BASE + 16'(np);
            CLS_ENG_LO: n_out.char_out = ENG_LO_BASE + 16'(np);
            default: begin
                n_out.char_out   = i_q_data.char_in;
                n_out.was_letter = 1'b0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Alphabet of the held result
    assign out_lt = f_classify(r_out.char_out);

`include "vigenere_caesar_letter_shift_assert.svh"

    `VCLS_ASSERT_IMPLIES(a_letter_out, i_clk, i_rst_n, r_out_valid && r_out.was_letter, out_lt.cls != CLS_NONE, "shifted letter left its alphabet")
    `VCLS_ASSERT_IMPLIES(a_other_out, i_clk, i_rst_n, r_out_valid && !r_out.was_letter, out_lt.cls == CLS_NONE, "passed character is a letter")

endmodule

`default_nettype wire

// ===== sv/vigenere_caesar_letter_shift.sv =====
// ----------------------------------------------------------------------------
// vigenere_caesar_letter_shift
// Caesar / Vigenere letter shifter for Ukrainian and English UTF-16 text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one character item
//   (char_in, message_start). Set message_start on the first character of a
//   message to restart the key at slot 0.
//   Output channel: o_out_valid / i_out_stall carry one result item per
//   input item (char_out, was_letter), in input order.
//   An accepted item is written into the queue and then loaded into the output
//   register, which raises o_out_valid. One item is taken and one result given
//   per cycle while the receiver does not stall, with the classify stage in front
//   and the shift-and-map stage behind a two-entry queue.
//   When the receiver stalls, the result holds in the output register, the
//   queue fills, and o_in_stall rises once both queue entries are taken.
//   Reset zeroes the settings (Vigenere, encrypt, empty key), key position and
//   output valid, and empties the queue; items are accepted from the first cycle after reset.
//   Write registers over the APB port only while no item is in flight; each
//   register sits at byte address 8 * index.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_caesar_letter_shift
    import vcls_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    t_cfg                    cfg;
    logic [KEY_SLOTS-1:0][5:0] key_shift;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_full;
    logic                    q_empty;
    t_work                   q_wdata;
    t_work                   q_rdata;

    vcls_regs #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (cfg),
        .o_key_shift (key_shift)
    );

    vcls_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .i_key_shift (key_shift),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    vcls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    vcls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== dv/vigenere_caesar_letter_shift_checker.sv =====
// ----------------------------------------------------------------------------
// vigenere_caesar_letter_shift_checker
// Watches the character channels and the register port of the letter shifter,
// predicts each shifted character from its own copy of the settings and key
// position, and compares every result item field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_caesar_letter_shift_checker
    import vcls_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  t_in_item         i_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  t_out_item        i_out,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [5:0]  i_paddr,
    input  wire logic [63:0] i_pwdata,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 12;
    localparam int CYR_COUNT   = 33;
    localparam int LAT_COUNT   = 26;
    localparam int PRINT_LIMIT = 20;

    localparam logic [15:0] LAT_UPPER_A = 16'h0041;
    localparam logic [15:0] LAT_LOWER_A = 16'h0061;

    // Ukrainian alphabet in collation order, capitals then small letters
    localparam logic [15:0] CYR_UPPER [CYR_COUNT] = '{
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0490, 16'h0414, 16'h0415,
        16'h0404, 16'h0416, 16'h0417, 16'h0418, 16'h0406, 16'h0407, 16'h0419,
        16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F, 16'h0420,
        16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042C, 16'h042E, 16'h042F
    };
    localparam logic [15:0] CYR_LOWER [CYR_COUNT] = '{
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0491, 16'h0434, 16'h0435,
        16'h0454, 16'h0436, 16'h0437, 16'h0438, 16'h0456, 16'h0457, 16'h0439,
        16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F, 16'h0440,
        16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044C, 16'h044E, 16'h044F
    };

    typedef struct {
        t_in_item  src;
        t_out_item res;
    } t_shifted_char;

    // Shadow settings and key position
    logic               cfg_caesar;
    logic               cfg_decrypt;
    logic signed [15:0] cfg_shift;
    logic [3:0]         cfg_key_len;
    logic [63:0]        cfg_key_word [3];
    int                 key_pos;

    t_shifted_char predicted_chars [$];
    int            mismatch_total = 0;
    int            pending_total  = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_total;

    // Find the alphabet of a code unit and its position in it
    function automatic t_cls letter_class(input logic [15:0] c, output int idx);
        t_cls cls;
        cls = CLS_NONE;
        idx = 0;
        for (int i = 0; i < CYR_COUNT; i++) begin
            if (c == CYR_UPPER[i]) begin
                cls = CLS_UKR_UP;
                idx = i;
            end
            if (c == CYR_LOWER[i]) begin
                cls = CLS_UKR_LO;
                idx = i;
            end
        end
        if (c >= LAT_UPPER_A && c < LAT_UPPER_A + LAT_COUNT) begin
            cls = CLS_ENG_UP;
            idx = int'(c - LAT_UPPER_A);
        end
        if (c >= LAT_LOWER_A && c < LAT_LOWER_A + LAT_COUNT) begin
            cls = CLS_ENG_LO;
            idx = int'(c - LAT_LOWER_A);
        end
        return cls;
    endfunction

    // Shift one character and advance the key position on letters
    function automatic t_out_item cipher_char(input t_in_item item);
        t_out_item   res;
        t_cls        cls;
        int          pos, kpos, alen, sh, np, klen, slot;
        logic [63:0] word;
        logic [15:0] kc;
        klen = (int'(cfg_key_len) > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_key_len);
        if (item.message_start) begin
            key_pos = 0;
        end
        slot = key_pos;
        if (slot >= klen) begin
            slot = 0;
        end
        res.char_out   = item.char_in;
        res.was_letter = 1'b0;
        cls = letter_class(item.char_in, pos);
        if (cls != CLS_NONE) begin
            alen = (cls == CLS_UKR_UP || cls == CLS_UKR_LO) ? CYR_COUNT : LAT_COUNT;
            if (cfg_caesar) begin
                sh = ((int'(cfg_shift) % alen) + alen) % alen;
            end else if (klen == 0) begin
                sh = 0;
            end else begin
                word = cfg_key_word[slot / 4];
                kc   = word[(slot % 4) * 16 +: 16];
                void'(letter_class(kc, kpos));
                sh = kpos % alen;
            end
            np = cfg_decrypt ? (pos + alen - sh) % alen : (pos + sh) % alen;
            case (cls)
                CLS_UKR_UP: res.char_out = CYR_UPPER[np];
                CLS_UKR_LO: res.char_out = CYR_LOWER[np];
                CLS_ENG_UP: res.char_out = LAT_UPPER_A + 16'(np);
                default:    res.char_out = LAT_LOWER_A + 16'(np);
            endcase
            res.was_letter = 1'b1;
            if (klen == 0) begin
                key_pos = 0;
            end else begin
                key_pos = (slot + 1 >= klen) ? 0 : slot + 1;
            end
        end
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input t_in_item src,
                                   input logic [15:0] got, input logic [15:0] want);
        if (mismatch_total < PRINT_LIMIT) begin
            $display("%0t mismatch %s: char_in %h start %b got %h want %h",
                     $realtime, what, src.char_in, src.message_start, got, want);
        end
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        t_shifted_char want;
        if (!i_rst_n) begin
            cfg_caesar      = 1'b0;
            cfg_decrypt     = 1'b0;
            cfg_shift       = '0;
            cfg_key_len     = '0;
            cfg_key_word[0] = '0;
            cfg_key_word[1] = '0;
            cfg_key_word[2] = '0;
            key_pos         = 0;
            predicted_chars.delete();
        end else begin
            // Compare a result item against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (predicted_chars.size() == 0) begin
                    report_mismatch("result with no item waiting", '0,
                                    i_out.char_out, '0);
                end else begin
                    want = predicted_chars.pop_front();
                    if (i_out.char_out !== want.res.char_out) begin
                        report_mismatch("char_out", want.src, i_out.char_out,
                                        want.res.char_out);
                    end
                    if (i_out.was_letter !== want.res.was_letter) begin
                        report_mismatch("was_letter", want.src, 16'(i_out.was_letter),
                                        16'(want.res.was_letter));
                    end
                end
            end
            // Predict an accepted item
            if (i_in_valid && !i_in_stall) begin
                want.src = i_in;
                want.res = cipher_char(i_in);
                predicted_chars.push_back(want);
            end
            // Track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[5:3]))
                    REG_CAESAR_MODE:  cfg_caesar      = i_pwdata[0];
                    REG_DECRYPT_MODE: cfg_decrypt     = i_pwdata[0];
                    REG_CAESAR_SHIFT: cfg_shift       = i_pwdata[15:0];
                    REG_KEY_LENGTH:   cfg_key_len     = i_pwdata[3:0];
                    REG_KEY_LOW:      cfg_key_word[0] = i_pwdata;
                    REG_KEY_MID:      cfg_key_word[1] = i_pwdata;
                    REG_KEY_HIGH:     cfg_key_word[2] = i_pwdata;
                    default: ;
                endcase
            end
        end
        pending_total = predicted_chars.size();
    end

endmodule

`default_nettype wire

// ===== dv/vigenere_caesar_letter_shift_tb.sv =====
// ----------------------------------------------------------------------------
// vigenere_caesar_letter_shift_tb
// Drives character items and register settings into the letter shifter:
// a short directed run over alphabet edges and shift extremes, then random
// messages under many Caesar and Vigenere settings with random gaps and
// stalls, a long output hold-off, and a quiet final stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_caesar_letter_shift_tb;
    import vcls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 40;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 28;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in        = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [5:0]  paddr       = '0;
    logic [63:0] pwdata      = '0;

    wire logic        o_in_stall;
    wire logic        o_out_valid;
    t_out_item        o_out;
    wire logic [63:0] prdata;
    wire logic        pready;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int gap_pct       = 0;
    bit rx_quiet      = 1'b0;
    int hold_requests = 0;
    int hold_served   = 0;

    vigenere_caesar_letter_shift dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    vigenere_caesar_letter_shift_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one item, hold it until taken, return at the next falling edge
    task automatic send_char(input logic [15:0] c, input logic start);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in.char_in        <= c;
        i_in.message_start  <= start;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result item is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Setup and access phase of one register write; psel stays up
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
    endtask

    // Load all settings while the block is idle
    task automatic apply_settings(input logic cm, input logic dm, input logic [15:0] sh,
                                  input logic [3:0] kl, input logic [63:0] kw0,
                                  input logic [63:0] kw1, input logic [63:0] kw2);
        settle();
        write_reg(REG_CAESAR_MODE, 64'(cm));
        write_reg(REG_DECRYPT_MODE, 64'(dm));
        write_reg(REG_CAESAR_SHIFT, 64'(sh));
        write_reg(REG_KEY_LENGTH, 64'(kl));
        write_reg(REG_KEY_LOW, kw0);
        write_reg(REG_KEY_MID, kw1);
        write_reg(REG_KEY_HIGH, kw2);
        // Unmapped index must leave everything alone
        write_reg(REG_UNUSED, {$urandom, $urandom});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Pick a text character: mostly letters, some near misses and noise
    function automatic logic [15:0] random_char();
        logic [15:0] c;
        case ($urandom_range(0, 9))
            0, 1:    c = UA_CAPITAL[$urandom_range(0, UKR_LEN - 1)];
            2, 3:    c = UA_SMALL[$urandom_range(0, UKR_LEN - 1)];
            4, 5:    c = ENG_UP_BASE + 16'($urandom_range(0, ENG_LEN - 1));
            6:       c = ENG_LO_BASE + 16'($urandom_range(0, ENG_LEN - 1));
            7:       c = 16'($urandom_range(16'h0400, 16'h049F));
            8:       c = 16'($urandom_range(0, 16'hFFFF));
            default: c = 16'($urandom_range(16'h0020, 16'h007F));
        endcase
        return c;
    endfunction

    // Key word of four characters, mostly letters
    function automatic logic [63:0] random_key_word();
        logic [63:0] w;
        for (int i = 0; i < 4; i++) begin
            w[i * 16 +: 16] = ($urandom_range(0, 3) == 0) ?
                              16'($urandom_range(0, 16'hFFFF)) : random_char();
        end
        return w;
    endfunction

    // One message of random text; a few stray restarts inside
    task automatic send_message(input int n, input logic first_start);
        for (int i = 0; i < n; i++) begin
            send_char(random_char(), (i == 0) ? first_start : ($urandom_range(0, 29) == 0));
        end
    endtask

    initial begin
        logic        cm, dm;
        logic [15:0] sh;
        logic [3:0]  kl;
        int          sent, n;
        bit          first;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: empty key, everything passes unshifted
        send_char(16'h0041, 1'b1);
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0000, 1'b0);

        // Caesar +1: wrap at the last letter of each alphabet
        apply_settings(1'b1, 1'b0, 16'h0001, 4'd0, '0, '0, '0);
        send_char(16'h005A, 1'b0);
        send_char(16'h007A, 1'b0);
        send_char(16'h042F, 1'b0);
        send_char(16'h044F, 1'b0);
        send_char(16'h0490, 1'b0);
        send_char(16'h0491, 1'b0);
        send_char(16'h0404, 1'b0);
        send_char(16'h0454, 1'b0);

        // Decrypt with the most negative shift; neighbors of letters pass
        apply_settings(1'b1, 1'b1, 16'h8000, 4'd0, '0, '0, '0);
        send_char(16'h0041, 1'b0);
        send_char(16'h0061, 1'b0);
        send_char(16'h0410, 1'b0);
        send_char(16'h0430, 1'b0);
        send_char(16'h0040, 1'b0);
        send_char(16'h005B, 1'b0);
        send_char(16'h0060, 1'b0);
        send_char(16'h007B, 1'b0);

        // Vigenere, oversized key length, key with non-letters
        apply_settings(1'b0, 1'b0, 16'h0000, 4'd15,
                       {16'h0042, 16'h007A, 16'h042F, 16'h0021},
                       {16'h044F, 16'h0000, 16'h0410, 16'h0491},
                       {16'h0454, 16'hFFFF, 16'h0061, 16'h005A});
        send_char(16'h0061, 1'b1);
        send_char(16'h0041, 1'b0);
        send_char(16'h002E, 1'b0);
        send_char(16'h0430, 1'b0);
        send_char(16'h0410, 1'b0);
        send_char(16'h007A, 1'b1);

        // Random phases over settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            cm = (p < 2) ? 1'b1 : 1'($urandom_range(0, 1));
            dm = (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0:       sh = 16'h7FFF;
                1:       sh = 16'h8000;
                2:       sh = 16'h0000;
                3:       sh = 16'hFFFF;
                4:       sh = 16'($signed($urandom_range(0, 80)) - 40);
                default: sh = 16'($urandom_range(0, 16'hFFFF));
            endcase
            if (p == 0) sh = 16'h7FFF;
            if (p == 1) sh = 16'h8000;
            case ($urandom_range(0, 5))
                0:       kl = 4'd0;
                1:       kl = 4'd12;
                2:       kl = 4'd15;
                3:       kl = 4'd1;
                default: kl = 4'($urandom_range(0, 15));
            endcase
            apply_settings(cm, dm, sh, kl, random_key_word(), random_key_word(),
                           random_key_word());

            if (p >= NUM_PHASES - 3) begin
                gap_pct  = 0;
                rx_quiet = 1'b1;
            end else begin
                gap_pct = (p % 3 == 2) ? 0 : 25;
            end
            // Long receiver hold-off while items keep coming
            if (p == 3) begin
                gap_pct = 0;
                hold_requests++;
            end

            sent  = 0;
            first = 1'b1;
            while (sent < PHASE_ITEMS) begin
                n = $urandom_range(1, 12);
                // Sometimes continue the old message across the settings change
                send_message(n, !(first && $urandom_range(0, 3) == 0));
                sent += n;
                first = 1'b0;
            end
        end

        // Drain and give the verdict
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/vcls_pkg.sv
sv/vcls_regs.sv
sv/vcls_front.sv
sv/vcls_fifo.sv
sv/vcls_back.sv
sv/vigenere_caesar_letter_shift.sv
dv/vigenere_caesar_letter_shift_checker.sv
dv/vigenere_caesar_letter_shift_tb.sv
